// ----- src/ang_pkg.sv -----
// Shared types and constants for the audio noise gate.
package ang_pkg;

    // Gain format: Q1.23, unity is 2^23.
    localparam int          GAIN_FRAC  = 23;
    localparam logic [23:0] GAIN_UNITY = 24'h80_0000;
    localparam logic [23:0] HOLD_MAX   = 24'hFF_FFFF;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_GATE_ENABLE     = 3'd0;
    localparam logic [2:0] REG_BYPASS_OUTPUT   = 3'd1;
    localparam logic [2:0] REG_OPEN_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_CLOSE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_ATTACK_STEP     = 3'd4;
    localparam logic [2:0] REG_RELEASE_STEP    = 3'd5;
    localparam logic [2:0] REG_HOLD_SAMPLES    = 3'd6;
    localparam logic [2:0] REG_DECAY_STEP      = 3'd7;

    // Register reset values.
    localparam logic [23:0] RST_OPEN_THRESHOLD  = 24'd420427;
    localparam logic [23:0] RST_CLOSE_THRESHOLD = 24'd210713;
    localparam logic [23:0] RST_ATTACK_STEP     = 24'd6990;
    localparam logic [23:0] RST_RELEASE_STEP    = 24'd1165;
    localparam logic [23:0] RST_HOLD_SAMPLES    = 24'd9600;
    localparam logic [23:0] RST_DECAY_STEP      = 24'd328;

    // All configuration registers as one bundle.
    typedef struct packed {
        logic        gate_enable;
        logic        bypass_output;
        logic [23:0] open_threshold;
        logic [23:0] close_threshold;
        logic [23:0] attack_step;
        logic [23:0] release_step;
        logic [23:0] hold_samples;
        logic [23:0] decay_step;
    } t_ang_cfg;

endpackage

// ----- src/ang_if.sv -----
// Valid/ready channel interfaces for the sample input and the gated result.
interface ang_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface ang_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          gate_open;
    logic [23:0]                   gain_now;

    modport source (output valid, output left_out, output right_out, output gate_open,
                    output gain_now, input ready);
    modport sink   (input valid, input left_out, input right_out, input gate_open,
                    input gain_now, output ready);
endinterface

// ----- src/ang_cfg.sv -----
// APB-style configuration register file for the noise gate.
module ang_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ang_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ang_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ang_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output ang_pkg::t_ang_cfg             o_cfg
);
    import ang_pkg::*;

    t_ang_cfg   r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Register writes; each register keeps the low bits of the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_enable     <= 1'b0;
            r_cfg.bypass_output   <= 1'b0;
            r_cfg.open_threshold  <= RST_OPEN_THRESHOLD;
            r_cfg.close_threshold <= RST_CLOSE_THRESHOLD;
            r_cfg.attack_step     <= RST_ATTACK_STEP;
            r_cfg.release_step    <= RST_RELEASE_STEP;
            r_cfg.hold_samples    <= RST_HOLD_SAMPLES;
            r_cfg.decay_step      <= RST_DECAY_STEP;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GATE_ENABLE:     r_cfg.gate_enable     <= pwdata[0];
                REG_BYPASS_OUTPUT:   r_cfg.bypass_output   <= pwdata[0];
                REG_OPEN_THRESHOLD:  r_cfg.open_threshold  <= pwdata[23:0];
                REG_CLOSE_THRESHOLD: r_cfg.close_threshold <= pwdata[23:0];
                REG_ATTACK_STEP:     r_cfg.attack_step     <= pwdata[23:0];
                REG_RELEASE_STEP:    r_cfg.release_step    <= pwdata[23:0];
                REG_HOLD_SAMPLES:    r_cfg.hold_samples    <= pwdata[23:0];
                REG_DECAY_STEP:      r_cfg.decay_step      <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            REG_GATE_ENABLE:     prdata = {31'd0, r_cfg.gate_enable};
            REG_BYPASS_OUTPUT:   prdata = {31'd0, r_cfg.bypass_output};
            REG_OPEN_THRESHOLD:  prdata = {8'd0, r_cfg.open_threshold};
            REG_CLOSE_THRESHOLD: prdata = {8'd0, r_cfg.close_threshold};
            REG_ATTACK_STEP:     prdata = {8'd0, r_cfg.attack_step};
            REG_RELEASE_STEP:    prdata = {8'd0, r_cfg.release_step};
            REG_HOLD_SAMPLES:    prdata = {8'd0, r_cfg.hold_samples};
            REG_DECAY_STEP:      prdata = {8'd0, r_cfg.decay_step};
            default:             prdata = '0;
        endcase
    end

endmodule

// ----- src/ang_front.sv -----
// Front end: accepts sample pairs, measures the level and flags the open crossing.
module ang_front #(
    parameter int SAMPLE_BITS = 24
) (
    ang_in_if.sink                   i_in,
    input  logic [23:0]              i_open_threshold,
    input  logic                     i_full,
    output logic                     o_push,
    output logic [3*SAMPLE_BITS:0]   o_push_data
);
    import ang_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;

    logic signed [SAMPLE_BITS:0]   sum;
    logic        [SAMPLE_BITS:0]   sum_abs;
    logic        [SAMPLE_BITS-1:0] level;
    logic        [CMP_W-1:0]       level_x;
    logic        [CMP_W-1:0]       thr_x;
    logic                          above_open;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Level is |left + right| / 2, truncated.
    assign sum     = {i_in.left_in[SAMPLE_BITS-1], i_in.left_in}
                   + {i_in.right_in[SAMPLE_BITS-1], i_in.right_in};
    assign sum_abs = sum[SAMPLE_BITS] ? (~sum + 1'b1) : sum;
    assign level   = sum_abs[SAMPLE_BITS:1];

    // Open-threshold crossing, compared unsigned at a common width.
    assign level_x    = CMP_W'(level);
    assign thr_x      = CMP_W'(i_open_threshold);
    assign above_open = level_x > thr_x;

    assign o_push_data = {i_in.left_in, i_in.right_in, level, above_open};

endmodule

// ----- src/ang_queue.sv -----
// Small register queue that decouples the front end from the gate core.
module ang_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);
    import ang_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic             do_push;
    logic             do_pop;

    assign o_full     = r_count == CW'(DEPTH);
    assign o_empty    = r_count == '0;
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointer wrap for any depth.
    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/ang_back.sv -----
// Gate core: updates gate state per sample, then scales the pair by the gain.
module ang_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ang_pkg::t_ang_cfg      i_cfg,
    input  logic                   i_empty,
    input  logic [3*SAMPLE_BITS:0] i_pop_data,
    output logic                   o_pop,
    ang_out_if.source              o_out
);
    import ang_pkg::*;

    localparam int CMP_W  = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
    localparam int PEAK_W = CMP_W + 2;
    localparam int PROD_W = SAMPLE_BITS + 25;

    // Request fields from the queue.
    logic signed [SAMPLE_BITS-1:0] q_left;
    logic signed [SAMPLE_BITS-1:0] q_right;
    logic        [SAMPLE_BITS-1:0] q_level;
    logic                          q_above;

    // Gate state.
    logic        [23:0]       r_gain;
    logic signed [PEAK_W-1:0] r_peak;
    logic        [23:0]       r_hold;
    logic                     r_is_open;
    logic        [23:0]       n_gain;
    logic signed [PEAK_W-1:0] n_peak;
    logic        [23:0]       n_hold;
    logic                     n_is_open;

    // Update-to-scale stage.
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_left;
    logic signed [SAMPLE_BITS-1:0] r_s1_right;
    logic        [23:0]            r_s1_gain;
    logic                          r_s1_open;
    logic                          r_s1_scale;

    // Output register.
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                          r_out_open;
    logic        [23:0]            r_out_gain;

    // Combinational update terms.
    logic                     adv;
    logic                     open_a;
    logic                     close_now;
    logic signed [PEAK_W-1:0] level_x;
    logic signed [PEAK_W-1:0] close_x;
    logic signed [PEAK_W-1:0] decay_x;
    logic signed [PEAK_W-1:0] peak_max;
    logic        [24:0]       gain_up;
    logic        [23:0]       hold_base;
    logic        [23:0]       hold_inc;
    logic signed [PROD_W-1:0] prod_l;
    logic signed [PROD_W-1:0] prod_r;

    assign {q_left, q_right, q_level, q_above} = i_pop_data;

    // The pipeline moves whenever the output register can take a result.
    assign adv   = !r_out_valid || o_out.ready;
    assign o_pop = adv && !i_empty;

    // Next gate state for the request at the queue head.
    always_comb begin
        level_x   = $signed(PEAK_W'(q_level));
        close_x   = $signed(PEAK_W'(i_cfg.close_threshold));
        decay_x   = $signed(PEAK_W'(i_cfg.decay_step));
        open_a    = r_is_open || q_above;
        close_now = open_a && (r_peak < close_x);
        peak_max  = (r_peak > level_x) ? r_peak : level_x;
        gain_up   = {1'b0, r_gain} + {1'b0, i_cfg.attack_step};
        hold_base = close_now ? '0 : r_hold;
        hold_inc  = (hold_base != HOLD_MAX) ? hold_base + 1'b1 : hold_base;

        n_is_open = open_a && !close_now;
        n_peak    = peak_max - decay_x;
        n_hold    = hold_base;
        n_gain    = r_gain;
        if (n_is_open) begin
            n_gain = (gain_up > {1'b0, GAIN_UNITY}) ? GAIN_UNITY : gain_up[23:0];
        end else begin
            n_hold = hold_inc;
            if (hold_inc > i_cfg.hold_samples) begin
                n_gain = (r_gain > i_cfg.release_step) ? r_gain - i_cfg.release_step
                                                       : '0;
            end
        end

        // A disabled gate sits at its reset state.
        if (!i_cfg.gate_enable) begin
            n_is_open = 1'b0;
            n_peak    = '0;
            n_hold    = '0;
            n_gain    = '0;
        end
    end

    // Gate state registers advance once per popped request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= '0;
            r_peak    <= '0;
            r_hold    <= '0;
            r_is_open <= 1'b0;
        end else if (o_pop) begin
            r_gain    <= n_gain;
            r_peak    <= n_peak;
            r_hold    <= n_hold;
            r_is_open <= n_is_open;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= !i_empty;
            r_out_valid <= r_s1_valid;
        end
    end

    // Stage payload: samples with the updated gain.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_left  <= q_left;
            r_s1_right <= q_right;
            r_s1_gain  <= n_gain;
            r_s1_open  <= n_is_open;
            r_s1_scale <= i_cfg.gate_enable && !i_cfg.bypass_output;
        end
    end

    // Gain multiply; the arithmetic shift by 23 is a part-select.
    assign prod_l = r_s1_left * $signed({1'b0, r_s1_gain});
    assign prod_r = r_s1_right * $signed({1'b0, r_s1_gain});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_left  <= r_s1_scale ? prod_l[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC]
                                      : r_s1_left;
            r_out_right <= r_s1_scale ? prod_r[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC]
                                      : r_s1_right;
            r_out_open  <= r_s1_open;
            r_out_gain  <= r_s1_gain;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;
    assign o_out.gate_open = r_out_open;
    assign o_out.gain_now  = r_out_gain;

endmodule

// ----- src/audio_noise_gate_unit.sv -----
// Stereo noise gate with hysteresis, attack, hold and release.
//
// Channels: i_in takes one stereo pair per request (left_in, right_in, signed).
// o_out returns one result per request in order: the gated pair, gate_open and
// gain_now (Q1.23). Registers are written over the APB-style port, four bytes
// apart; the user must write only while no request is in flight (not enforced).
// Path: an accepted request is written into the queue, then updates the gate
// state into the update-to-scale stage, then is scaled into the output register.
// Throughput: one pair per cycle while o_out is not stalled. The gate state
// recurrence closes around the state registers; the multiply has its own stage.
// Stall: when o_out.ready is low the output register holds, the core stops
// popping, and the front keeps accepting until the four-entry queue fills.
// Reset: i_rst_n (synchronous, active low) empties the pipeline, clears the gate
// state (gain, peak, hold count, open flag) and loads the register defaults,
// with the gate disabled so samples pass unchanged.
module audio_noise_gate_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ang_in_if.sink                         i_in,
    ang_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ang_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ang_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ang_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ang_pkg::*;

    localparam int ENTRY_W = 3 * SAMPLE_BITS + 1;

    t_ang_cfg           cfg;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               full;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;
    logic               empty;

    // Configuration registers.
    ang_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Level measurement and intake.
    ang_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_in             (i_in),
        .i_open_threshold (cfg.open_threshold),
        .i_full           (full),
        .o_push           (push),
        .o_push_data      (push_data)
    );

    // Decoupling queue.
    ang_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    // Gate state and gain stage.
    ang_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_empty    (empty),
        .i_pop_data (pop_data),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ----- verif/audio_noise_gate_unit_tb.sv -----
// Self-checking testbench for the audio noise gate: random sample streams against a gate predictor.
module audio_noise_gate_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ang_pkg::*;

    localparam int                 PHASE_ITEMS = 48;
    localparam int                 CYCLE_LIMIT = 200_000;
    localparam longint             UNITY       = longint'(GAIN_UNITY);
    localparam longint             HOLD_TOP    = longint'(HOLD_MAX);
    localparam logic signed [23:0] FULL_POS    = 24'sh7F_FFFF;
    localparam logic signed [23:0] FULL_NEG    = 24'sh80_0000;

    // One gated result as it leaves the block.
    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               open;
        logic [23:0]        gain;
    } t_gated_pair;

    // Tracks the gate state and the gated pairs still owed by the block.
    class gate_tracker;
        bit          enable;
        bit          bypass;
        longint      open_thr;
        longint      close_thr;
        longint      attack_step;
        longint      rel_step;
        longint      hold_limit;
        longint      decay_step;
        longint      gain;
        longint      peak;
        longint      hold_cnt;
        bit          is_open;
        t_gated_pair gated_q[$];
        int          errors;

        function new();
            enable      = 1'b0;
            bypass      = 1'b0;
            open_thr    = longint'(RST_OPEN_THRESHOLD);
            close_thr   = longint'(RST_CLOSE_THRESHOLD);
            attack_step = longint'(RST_ATTACK_STEP);
            rel_step    = longint'(RST_RELEASE_STEP);
            hold_limit  = longint'(RST_HOLD_SAMPLES);
            decay_step  = longint'(RST_DECAY_STEP);
            errors      = 0;
            clear_gate_state();
        endfunction

        function void clear_gate_state();
            gain     = 0;
            peak     = 0;
            hold_cnt = 0;
            is_open  = 1'b0;
        endfunction

        // Registers keep only their low bits.
        function void set_reg(logic [2:0] idx, logic [23:0] v);
            case (idx)
                REG_GATE_ENABLE:     enable      = v[0];
                REG_BYPASS_OUTPUT:   bypass      = v[0];
                REG_OPEN_THRESHOLD:  open_thr    = longint'(v);
                REG_CLOSE_THRESHOLD: close_thr   = longint'(v);
                REG_ATTACK_STEP:     attack_step = longint'(v);
                REG_RELEASE_STEP:    rel_step    = longint'(v);
                REG_HOLD_SAMPLES:    hold_limit  = longint'(v);
                REG_DECAY_STEP:      decay_step  = longint'(v);
                default: ;
            endcase
        endfunction

        // Product with the gain, shifted down with rounding toward minus infinity.
        function longint scaled(longint s);
            return (s * gain) >>> GAIN_FRAC;
        endfunction

        // Advance the gate by one accepted pair and queue the result it owes.
        function void note_pair(logic signed [23:0] l, logic signed [23:0] r);
            t_gated_pair want;
            longint      sum;
            longint      lvl;
            want.left  = l;
            want.right = r;
            if (!enable) begin
                clear_gate_state();
            end else begin
                sum = longint'(l) + longint'(r);
                lvl = ((sum < 0) ? -sum : sum) >>> 1;
                // Open on the new level, close on the peak left by earlier samples.
                if (lvl > open_thr && !is_open) begin
                    is_open = 1'b1;
                end
                if (peak < close_thr && is_open) begin
                    hold_cnt = 0;
                    is_open  = 1'b0;
                end
                // The peak is signed and may drop below zero.
                peak = ((peak > lvl) ? peak : lvl) - decay_step;
                if (is_open) begin
                    gain = (gain + attack_step > UNITY) ? UNITY : gain + attack_step;
                end else begin
                    if (hold_cnt < HOLD_TOP) begin
                        hold_cnt++;
                    end
                    if (hold_cnt > hold_limit) begin
                        gain = (gain > rel_step) ? gain - rel_step : 0;
                    end
                end
                if (!bypass) begin
                    want.left  = 24'(scaled(longint'(l)));
                    want.right = 24'(scaled(longint'(r)));
                end
            end
            want.open = is_open;
            want.gain = 24'(gain);
            gated_q.push_back(want);
        endfunction

        function void check_field(string name, logic signed [24:0] want, logic signed [24:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare a result with the oldest pending one.
        function void check_gated(t_gated_pair got);
            t_gated_pair want;
            if (gated_q.size() == 0) begin
                $display("%0t: result with no pending request, expected none, actual %0d %0d",
                         $time, got.left, got.right);
                errors++;
                return;
            end
            want = gated_q.pop_front();
            check_field("left_out", 25'(want.left), 25'(got.left));
            check_field("right_out", 25'(want.right), 25'(got.right));
            check_field("gate_open", 25'(want.open), 25'(got.open));
            check_field("gain_now", 25'(want.gain), 25'(got.gain));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          idle_on = 1'b1;
    int          cycles  = 0;
    t_gated_pair seen;
    gate_tracker sb;

    ang_in_if  #(.SAMPLE_BITS(24)) in_ch ();
    ang_out_if #(.SAMPLE_BITS(24)) out_ch ();

    audio_noise_gate_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watch both channels; values read here are the ones sampled at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_pair(in_ch.left_in, in_ch.right_in);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.left  = out_ch.left_out;
            seen.right = out_ch.right_out;
            seen.open  = out_ch.gate_open;
            seen.gain  = out_ch.gain_now;
            sb.check_gated(seen);
        end
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before taking each result.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // Send one stereo request after a random gap and wait until it is taken.
    task automatic send_pair(input logic signed [23:0] l, input logic signed [23:0] r);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stop sending and let every pending result drain out of the pipeline.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.gated_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Register write: setup then access; unused upper data bits are sometimes junk.
    task automatic reg_write(input logic [2:0] idx, input logic [23:0] val);
        logic [31:0] junk;
        junk    = $urandom_range(0, 1) ? $urandom : 32'd0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        if (idx == REG_GATE_ENABLE || idx == REG_BYPASS_OUTPUT) begin
            pwdata <= {junk[31:1], val[0]};
        end else begin
            pwdata <= {junk[31:24], val};
        end
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic load_gate_settings(input logic en, input logic byp,
                                      input logic [23:0] open_thr, input logic [23:0] close_thr,
                                      input logic [23:0] atk, input logic [23:0] rel,
                                      input logic [23:0] hold, input logic [23:0] dec);
        reg_write(REG_OPEN_THRESHOLD, open_thr);
        reg_write(REG_CLOSE_THRESHOLD, close_thr);
        reg_write(REG_ATTACK_STEP, atk);
        reg_write(REG_RELEASE_STEP, rel);
        reg_write(REG_HOLD_SAMPLES, hold);
        reg_write(REG_DECAY_STEP, dec);
        reg_write(REG_BYPASS_OUTPUT, {23'd0, byp});
        reg_write(REG_GATE_ENABLE, {23'd0, en});
    endtask

    function automatic logic signed [23:0] pick_sample(int unsigned lo, int unsigned hi);
        logic signed [23:0] mag;
        mag = 24'($urandom_range(hi, lo));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // One random phase: new settings, then bursts, quiet tails and noise.
    task automatic run_phase(input int p);
        logic               en;
        logic               byp;
        logic [23:0]        open_thr;
        logic [23:0]        close_thr;
        logic [23:0]        atk;
        logic [23:0]        rel;
        logic [23:0]        hold;
        logic [23:0]        dec;
        logic signed [23:0] l;
        int                 sent;
        int                 run;
        sent      = 0;
        idle_on   = ($urandom_range(0, 3) != 0);
        en        = 1'b1;
        byp       = 1'b0;
        open_thr  = 24'($urandom_range(1 << 22, 1 << 12));
        close_thr = 24'($urandom_range(32'(open_thr), 0));
        atk       = 24'($urandom_range(1 << 23, 1 << 18));
        rel       = 24'($urandom_range(1 << 23, 1 << 18));
        hold      = 24'($urandom_range(6, 0));
        dec       = 24'($urandom_range(1 << 21, 1 << 14));
        case (p)
            1: byp = 1'b1;
            2: en = 1'b0;
            3: begin
                open_thr  = 24'd0;
                close_thr = 24'd0;
                atk       = 24'hFF_FFFF;
                rel       = 24'hFF_FFFF;
                hold      = 24'd0;
                dec       = 24'd0;
            end
            4: begin
                open_thr  = 24'hFF_FFFF;
                close_thr = 24'hFF_FFFF;
                atk       = 24'd0;
                rel       = 24'd0;
                hold      = 24'hFF_FFFF;
                dec       = 24'hFF_FFFF;
            end
            5: begin
                open_thr  = RST_OPEN_THRESHOLD;
                close_thr = RST_CLOSE_THRESHOLD;
                atk       = RST_ATTACK_STEP;
                rel       = RST_RELEASE_STEP;
                hold      = RST_HOLD_SAMPLES;
                dec       = RST_DECAY_STEP;
            end
            6: begin
                open_thr  = 24'd0;
                close_thr = GAIN_UNITY;
            end
            default: ;
        endcase
        load_gate_settings(en, byp, open_thr, close_thr, atk, rel, hold, dec);
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                // A loud burst, then a quiet tail that may reach hold and release.
                run = $urandom_range(1, 6);
                for (int k = 0; k < run; k++) begin
                    l = pick_sample(1 << 21, (1 << 23) - 1);
                    send_pair(l, l ^ 24'($urandom_range(0, 255)));
                end
                sent += run;
                run = $urandom_range(2, 10);
                for (int k = 0; k < run; k++) begin
                    send_pair(pick_sample(0, 1 << 10), pick_sample(0, 1 << 10));
                end
                sent += run;
            end else begin
                run = $urandom_range(1, 4);
                for (int k = 0; k < run; k++) begin
                    send_pair(24'($urandom), 24'($urandom));
                end
                sent += run;
            end
        end
        settle();
    endtask

    initial begin
        sb             = new();
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.left_in  <= '0;
        in_ch.right_in <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gate disabled after reset: samples pass unchanged.
        send_pair(FULL_POS, FULL_NEG);
        send_pair(FULL_NEG, FULL_POS);
        send_pair(24'sd0, 24'sd0);
        send_pair(-24'sd1, 24'sd1);
        settle();

        // Fast gate with a deep decay: the first loud pair opens and closes at once,
        // the gain saturates at unity, then the peak goes negative and release runs.
        load_gate_settings(1'b1, 1'b0, 24'd1000, 24'd500, 24'd1 << 22, 24'd1 << 21, 24'd2,
                           24'd1 << 22);
        send_pair(FULL_POS, FULL_POS);
        send_pair(FULL_POS, FULL_POS);
        send_pair(FULL_NEG, FULL_NEG);
        send_pair(FULL_NEG, FULL_POS);
        send_pair(-24'sd1, 24'sd1);
        send_pair(24'sd0, 24'sd0);
        send_pair(-24'sd3, 24'sd5);
        send_pair(24'sd1, -24'sd1);
        send_pair(-24'sd1, -24'sd1);
        send_pair(24'sd0, 24'sd0);
        send_pair(24'sd7, -24'sd7);
        settle();

        // Bypass keeps the gate running while the samples pass unscaled.
        reg_write(REG_BYPASS_OUTPUT, 24'd1);
        send_pair(FULL_POS, FULL_POS);
        send_pair(-24'sd1000, 24'sd2000);
        send_pair(24'sd5, 24'sd5);
        settle();

        // Longest hold: once closed, release never begins.
        reg_write(REG_BYPASS_OUTPUT, 24'd0);
        reg_write(REG_HOLD_SAMPLES, 24'hFF_FFFF);
        send_pair(FULL_NEG, FULL_NEG);
        send_pair(24'sd0, 24'sd0);
        send_pair(24'sd0, 24'sd0);
        send_pair(-24'sd2, 24'sd0);
        settle();

        for (int p = 0; p < 8; p++) begin
            run_phase(p);
        end

        if (sb.errors == 0 && sb.gated_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
